[src/qbp_pkg.sv]
// Package for the queue batch planner: request and result structs, event codes,
// datapath operation codes and the status struct. It depends on nothing else.
package qbp_pkg;

  localparam int MAX_PASSES   = 256;
  localparam int MAX_BATCHES  = 256;
  localparam int MAX_DEPS     = 16;
  localparam int NUM_FAMILIES = 4;

  localparam int PASS_W  = $clog2(MAX_PASSES);
  localparam int BATCH_W = $clog2(MAX_BATCHES);
  localparam int CNT_W   = BATCH_W + 1;
  localparam int FAM_W   = $clog2(NUM_FAMILIES);
  localparam int SIG_W   = 9;
  localparam int IDX_W   = $clog2(MAX_DEPS);
  localparam int FCNT_W  = IDX_W + 1;
  localparam int KIND_W  = 3;

  localparam logic [SIG_W-1:0] SIG_MAX = '1;

  localparam logic REQ_DEP = 1'b0;
  localparam logic REQ_END = 1'b1;

  localparam logic [KIND_W-1:0] EV_SEALED   = 3'd0;
  localparam logic [KIND_W-1:0] EV_OPENED   = 3'd1;
  localparam logic [KIND_W-1:0] EV_WAIT     = 3'd2;
  localparam logic [KIND_W-1:0] EV_ASSIGN   = 3'd3;
  localparam logic [KIND_W-1:0] EV_OVERFLOW = 3'd4;
  localparam logic [KIND_W-1:0] EV_DONE     = 3'd5;

  typedef struct packed {
    logic              req_type;
    logic [PASS_W-1:0] pass_index;
    logic [1:0]        pass_family;
    logic [PASS_W-1:0] dep_index;
    logic              dep_valid;
    logic              last_of_pass;
  } in_req_t;

  typedef struct packed {
    logic [KIND_W-1:0]  event_kind;
    logic [BATCH_W-1:0] batch_index;
    logic [BATCH_W-1:0] waited_batch;
    logic [SIG_W-1:0]   signal_value;
    logic [1:0]         queue_family;
    logic [PASS_W-1:0]  placed_pass;
    logic               last;
  } out_res_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOOK, OP_COLLECT, OP_FR_RD, OP_FR_SEAL, OP_OWN_RD, OP_OWN_SEAL,
    OP_PICK, OP_OPEN, OP_WOWN_RD, OP_WOWN_EM, OP_WF_RD, OP_WF_EM, OP_ASSIGN,
    OP_END_RD, OP_END_SEAL, OP_DONE
  } op_t;

  typedef struct packed {
    logic fcount_zero;
    logic walk_last;
    logic own_open;
    logic batch_full;
    logic have_own;
    logic fi_last;
    logic last_of_pass;
  } status_t;

endpackage

[src/qbp_dp.sv]
// Datapath of the queue batch planner: pass and batch tables, per-family state,
// the sorted foreign list and the result register. Depends on qbp_pkg.
module qbp_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  qbp_pkg::in_req_t in_req,
  input  qbp_pkg::op_t     op,
  output qbp_pkg::status_t status,
  output logic             out_valid,
  output qbp_pkg::out_res_t out_res
);
  import qbp_pkg::*;

  logic [BATCH_W-1:0]       ptb_mem [MAX_PASSES];
  logic [FAM_W+SIG_W-1:0]   tbl_mem [MAX_BATCHES];
  logic [MAX_PASSES-1:0]    pv_r;
  logic [BATCH_W-1:0]       ptb_q_r;
  logic [FAM_W+SIG_W-1:0]   tbl_q_r;
  logic [BATCH_W-1:0]       rd_addr_r;
  logic [NUM_FAMILIES-1:0]  open_v_r;
  logic [BATCH_W-1:0]       open_b_r [NUM_FAMILIES];
  logic [SIG_W-1:0]         next_sig_r [NUM_FAMILIES];
  logic [CNT_W-1:0]         bcount_r;
  logic [BATCH_W-1:0]       fl_r [MAX_DEPS];
  logic [FCNT_W-1:0]        fcount_r;
  logic                     ovf_r;
  logic                     hit_r;
  logic                     lastp_r;
  logic [FAM_W-1:0]         fam_r;
  logic [PASS_W-1:0]        pidx_r;
  logic [IDX_W-1:0]         idx_r;
  logic [FAM_W-1:0]         fi_r;
  logic                     have_own_r;
  logic [BATCH_W-1:0]       target_r;
  logic                     out_valid_r;
  out_res_t                 out_res_r;

  logic [BATCH_W-1:0]       tbl_raddr;
  logic                     tbl_we;
  logic [BATCH_W-1:0]       tbl_waddr;
  logic [FAM_W+SIG_W-1:0]   tbl_wdata;
  logic [FAM_W-1:0]         sf;
  logic [SIG_W-1:0]         sig_q;
  logic [SIG_W:0]           inc;
  logic                     sat;
  logic [SIG_W-1:0]         seal_v;
  logic                     seal_do;
  logic [MAX_DEPS-1:0]      lt;
  logic [MAX_DEPS-1:0]      dup;
  logic [BATCH_W-1:0]       fl_ins [MAX_DEPS];
  logic                     batch_full;
  out_res_t                 out_res_nxt;

  assign sf         = tbl_q_r[SIG_W +: FAM_W];
  assign sig_q      = tbl_q_r[SIG_W-1:0];
  assign inc        = {1'b0, next_sig_r[sf]} + (SIG_W+1)'(1);
  assign sat        = inc > {1'b0, SIG_MAX};
  assign seal_v     = sat ? SIG_MAX : inc[SIG_W-1:0];
  assign batch_full = bcount_r == CNT_W'(MAX_BATCHES);

  always_comb begin
    seal_do = 1'b0;
    case (op)
      OP_FR_SEAL, OP_OWN_SEAL: seal_do = (sig_q == '0);
      OP_END_SEAL:             seal_do = open_v_r[fi_r] && (sig_q == '0);
      default:                 seal_do = 1'b0;
    endcase
  end

  always_comb begin
    tbl_raddr = '0;
    case (op)
      OP_LOOK:             tbl_raddr = ptb_q_r;
      OP_FR_RD, OP_WF_RD:  tbl_raddr = fl_r[idx_r];
      OP_OWN_RD:           tbl_raddr = open_b_r[fam_r];
      OP_OWN_SEAL, OP_OPEN, OP_WOWN_RD: tbl_raddr = rd_addr_r;
      OP_END_RD:           tbl_raddr = open_b_r[fi_r];
      default:             tbl_raddr = '0;
    endcase
  end

  always_comb begin
    tbl_we    = seal_do;
    tbl_waddr = rd_addr_r;
    tbl_wdata = {sf, seal_v};
    if (op == OP_OPEN && !batch_full) begin
      tbl_we    = 1'b1;
      tbl_waddr = bcount_r[BATCH_W-1:0];
      tbl_wdata = {fam_r, {SIG_W{1'b0}}};
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_DEPS; i++) begin
      lt[i]  = (FCNT_W'(i) < fcount_r) && (fl_r[i] < ptb_q_r);
      dup[i] = (FCNT_W'(i) < fcount_r) && (fl_r[i] == ptb_q_r);
    end
    fl_ins[0] = lt[0] ? fl_r[0] : ptb_q_r;
    for (int i = 1; i < MAX_DEPS; i++) begin
      if (lt[i]) begin
        fl_ins[i] = fl_r[i];
      end else if (lt[i-1]) begin
        fl_ins[i] = ptb_q_r;
      end else begin
        fl_ins[i] = fl_r[i-1];
      end
    end
  end

  always_comb begin
    out_res_nxt = '0;
    if (seal_do) begin
      out_res_nxt.event_kind   = EV_SEALED;
      out_res_nxt.batch_index  = rd_addr_r;
      out_res_nxt.signal_value = seal_v;
      out_res_nxt.queue_family = sf;
    end
    case (op)
      OP_OPEN: begin
        out_res_nxt.queue_family = fam_r;
        if (batch_full) begin
          out_res_nxt.event_kind  = EV_OVERFLOW;
          out_res_nxt.placed_pass = pidx_r;
          out_res_nxt.last        = 1'b1;
        end else begin
          out_res_nxt.event_kind  = EV_OPENED;
          out_res_nxt.batch_index = bcount_r[BATCH_W-1:0];
        end
      end
      OP_WOWN_EM, OP_WF_EM: begin
        out_res_nxt.event_kind   = EV_WAIT;
        out_res_nxt.batch_index  = target_r;
        out_res_nxt.waited_batch = rd_addr_r;
        out_res_nxt.signal_value = sig_q;
        out_res_nxt.queue_family = fam_r;
      end
      OP_ASSIGN: begin
        out_res_nxt.event_kind   = EV_ASSIGN;
        out_res_nxt.batch_index  = target_r;
        out_res_nxt.queue_family = fam_r;
        out_res_nxt.placed_pass  = pidx_r;
        out_res_nxt.last         = 1'b1;
      end
      OP_DONE: begin
        out_res_nxt.event_kind   = EV_DONE;
        out_res_nxt.waited_batch = BATCH_W'(ovf_r);
        out_res_nxt.signal_value = bcount_r;
        out_res_nxt.last         = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ptb_q_r <= ptb_mem[in_req.dep_index];
    end
    if (op == OP_ASSIGN) begin
      ptb_mem[pidx_r] <= target_r;
    end
    tbl_q_r   <= tbl_mem[tbl_raddr];
    rd_addr_r <= tbl_raddr;
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fam_r   <= in_req.pass_family;
      pidx_r  <= in_req.pass_index;
      lastp_r <= in_req.last_of_pass;
    end
    if (op == OP_COLLECT && hit_r && sf != fam_r && !(|dup) &&
        fcount_r != FCNT_W'(MAX_DEPS)) begin
      fl_r <= fl_ins;
    end
    if (op == OP_PICK) begin
      target_r <= open_b_r[fam_r];
    end
    if (op == OP_OPEN) begin
      target_r <= bcount_r[BATCH_W-1:0];
    end
    if (op == OP_OWN_SEAL || op == OP_OPEN) begin
      open_b_r[fam_r] <= (op == OP_OPEN) ? bcount_r[BATCH_W-1:0] : open_b_r[fam_r];
    end
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r        <= '0;
      open_v_r    <= '0;
      bcount_r    <= '0;
      fcount_r    <= '0;
      ovf_r       <= 1'b0;
      hit_r       <= 1'b0;
      idx_r       <= '0;
      fi_r        <= '0;
      have_own_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int f = 0; f < NUM_FAMILIES; f++) begin
        next_sig_r[f] <= '0;
      end
    end else begin
      out_valid_r <= seal_do || op == OP_OPEN || op == OP_WOWN_EM || op == OP_WF_EM ||
                     op == OP_ASSIGN || op == OP_DONE;
      if (accept) begin
        hit_r      <= in_req.dep_valid && pv_r[in_req.dep_index];
        fi_r       <= '0;
        have_own_r <= 1'b0;
      end
      if (seal_do) begin
        next_sig_r[sf] <= seal_v;
        if (sat) begin
          ovf_r <= 1'b1;
        end
      end
      case (op)
        OP_COLLECT: begin
          idx_r <= '0;
          if (hit_r && sf != fam_r && !(|dup)) begin
            if (fcount_r == FCNT_W'(MAX_DEPS)) begin
              ovf_r <= 1'b1;
            end else begin
              fcount_r <= fcount_r + FCNT_W'(1);
            end
          end
        end
        OP_FR_SEAL: begin
          open_v_r[sf] <= 1'b0;
          idx_r        <= idx_r + IDX_W'(1);
        end
        OP_OWN_SEAL: begin
          open_v_r[sf] <= 1'b0;
          have_own_r   <= 1'b1;
        end
        OP_OPEN: begin
          idx_r <= '0;
          if (batch_full) begin
            ovf_r    <= 1'b1;
            fcount_r <= '0;
          end else begin
            open_v_r[fam_r] <= 1'b1;
            bcount_r        <= bcount_r + CNT_W'(1);
          end
        end
        OP_WF_EM: begin
          idx_r <= idx_r + IDX_W'(1);
        end
        OP_ASSIGN: begin
          pv_r[pidx_r] <= 1'b1;
          fcount_r     <= '0;
        end
        OP_END_SEAL: begin
          fi_r <= fi_r + FAM_W'(1);
        end
        OP_DONE: begin
          pv_r     <= '0;
          open_v_r <= '0;
          bcount_r <= '0;
          fcount_r <= '0;
          ovf_r    <= 1'b0;
          for (int f = 0; f < NUM_FAMILIES; f++) begin
            next_sig_r[f] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign status.fcount_zero  = fcount_r == '0;
  assign status.walk_last    = ({1'b0, idx_r} + FCNT_W'(1)) == fcount_r;
  assign status.own_open     = open_v_r[fam_r];
  assign status.batch_full   = batch_full;
  assign status.have_own     = have_own_r;
  assign status.fi_last      = fi_r == FAM_W'(NUM_FAMILIES - 1);
  assign status.last_of_pass = lastp_r;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

[src/qbp_ctrl.sv]
// Controller of the queue batch planner: sequences lookups, seals, opens, waits
// and end-of-graph handling. Depends on qbp_pkg.
module qbp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             req_type,
  input  qbp_pkg::status_t status,
  output qbp_pkg::op_t     op,
  output logic             busy
);
  import qbp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LOOK, S_COLLECT, S_DECIDE, S_FR_RD, S_FR_SEAL, S_OWN_RD, S_OWN_SEAL,
    S_PICK, S_OPEN, S_WOWN_RD, S_WOWN_EM, S_WF_RD, S_WF_EM, S_ASSIGN,
    S_END_RD, S_END_SEAL, S_DONE
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= (req_type == REQ_END) ? S_END_RD : S_LOOK;
          end
        end
        S_LOOK:     state_r <= S_COLLECT;
        S_COLLECT:  state_r <= status.last_of_pass ? S_DECIDE : S_IDLE;
        S_DECIDE: begin
          if (!status.fcount_zero) begin
            state_r <= S_FR_RD;
          end else begin
            state_r <= status.own_open ? S_PICK : S_OPEN;
          end
        end
        S_FR_RD:    state_r <= S_FR_SEAL;
        S_FR_SEAL:  state_r <= status.walk_last ? S_OWN_RD : S_FR_RD;
        S_OWN_RD:   state_r <= status.own_open ? S_OWN_SEAL : S_OPEN;
        S_OWN_SEAL: state_r <= S_OPEN;
        S_PICK:     state_r <= S_ASSIGN;
        S_OPEN: begin
          if (status.batch_full) begin
            state_r <= S_IDLE;
          end else if (status.have_own) begin
            state_r <= S_WOWN_RD;
          end else begin
            state_r <= status.fcount_zero ? S_ASSIGN : S_WF_RD;
          end
        end
        S_WOWN_RD:  state_r <= S_WOWN_EM;
        S_WOWN_EM:  state_r <= status.fcount_zero ? S_ASSIGN : S_WF_RD;
        S_WF_RD:    state_r <= S_WF_EM;
        S_WF_EM:    state_r <= status.walk_last ? S_ASSIGN : S_WF_RD;
        S_ASSIGN:   state_r <= S_IDLE;
        S_END_RD:   state_r <= S_END_SEAL;
        S_END_SEAL: state_r <= status.fi_last ? S_DONE : S_END_RD;
        S_DONE:     state_r <= S_IDLE;
        default:    state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (state_r)
      S_LOOK:     op = OP_LOOK;
      S_COLLECT:  op = OP_COLLECT;
      S_FR_RD:    op = OP_FR_RD;
      S_FR_SEAL:  op = OP_FR_SEAL;
      S_OWN_RD:   op = OP_OWN_RD;
      S_OWN_SEAL: op = OP_OWN_SEAL;
      S_PICK:     op = OP_PICK;
      S_OPEN:     op = OP_OPEN;
      S_WOWN_RD:  op = OP_WOWN_RD;
      S_WOWN_EM:  op = OP_WOWN_EM;
      S_WF_RD:    op = OP_WF_RD;
      S_WF_EM:    op = OP_WF_EM;
      S_ASSIGN:   op = OP_ASSIGN;
      S_END_RD:   op = OP_END_RD;
      S_END_SEAL: op = OP_END_SEAL;
      S_DONE:     op = OP_DONE;
      default:    op = OP_NONE;
    endcase
  end

  assign busy = state_r != S_IDLE;

endmodule

[src/queue_batch_planner.sv]
// Queue batch planner top level: joins the controller and the datapath.
// A dependency request without the pass end runs a lookup and a collect step; a pass end
// also reads and seals each foreign batch and its own open batch, opens or picks a batch
// and emits each wait. An end-of-graph request walks every family to seal its open batch.
// Results follow in the cycle after they are formed and cannot be stalled.
// Synchronous active-low reset empties all tables and counters at once.
module queue_batch_planner (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  qbp_pkg::in_req_t   in_req,
  output logic               out_valid,
  output qbp_pkg::out_res_t  out_res
);
  import qbp_pkg::*;

  logic    accept;
  op_t     op;
  status_t status;

  assign accept = start && !busy;

  qbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .req_type (in_req.req_type),
    .status   (status),
    .op       (op),
    .busy     (busy)
  );

  qbp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_req    (in_req),
    .op        (op),
    .status    (status),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.last |-> !busy)
    else $error("Final result while a request is still in progress.");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("Accepted request did not start work.");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.event_kind == EV_DONE |-> out_res.last)
    else $error("Graph done result not marked last.");

endmodule

[tb/sv/tb_queue_batch_planner.sv]
// Self-checking testbench for queue_batch_planner: drives pass and end-of-graph
// requests, predicts every batch event in a behavioral planner model and checks it.
// It depends on qbp_pkg and the queue_batch_planner RTL.
`timescale 1ns / 1ps

module tb_queue_batch_planner;
  import qbp_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  in_req_t  in_req = '0;
  logic     out_valid;
  out_res_t out_res;

  queue_batch_planner i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res)
  );

  always #1 clk = ~clk;

  out_res_t event_q[$];
  int       err_cnt = 0;
  int       req_cnt = 0;
  int       idle_pct = 0;

  int       pass_batch[MAX_PASSES];
  int       batch_fam[MAX_BATCHES];
  int       batch_sig[MAX_BATCHES];
  int       open_batch[NUM_FAMILIES];
  int       next_sig[NUM_FAMILIES];
  int       batch_cnt;
  int       foreign[MAX_DEPS];
  int       foreign_cnt;
  bit       ovf;

  int       placed_q[$];
  int       next_pass = 0;

  function automatic void clear_plan();
    foreach (pass_batch[i]) pass_batch[i] = 0;
    foreach (batch_fam[i]) batch_fam[i] = 0;
    foreach (batch_sig[i]) batch_sig[i] = 0;
    foreach (open_batch[i]) open_batch[i] = 0;
    foreach (next_sig[i]) next_sig[i] = 0;
    batch_cnt = 0;
    foreign_cnt = 0;
    ovf = 1'b0;
  endfunction

  function automatic void push_event(logic [KIND_W-1:0] kind, int b, int w, int s, int f,
                                     int p);
    out_res_t e;
    e.event_kind   = kind;
    e.batch_index  = b[BATCH_W-1:0];
    e.waited_batch = w[BATCH_W-1:0];
    e.signal_value = s[SIG_W-1:0];
    e.queue_family = f[1:0];
    e.placed_pass  = p[PASS_W-1:0];
    e.last         = 1'b0;
    event_q = {event_q, e};
  endfunction

  function automatic void seal_batch(int b);
    int f;
    int v;
    if (b >= MAX_BATCHES || batch_sig[b] != 0) return;
    f = batch_fam[b] % NUM_FAMILIES;
    v = next_sig[f] + 1;
    if (v > SIG_MAX) begin
      v = SIG_MAX;
      ovf = 1'b1;
    end
    next_sig[f] = v;
    batch_sig[b] = v;
    push_event(EV_SEALED, b, 0, v, f, 0);
  endfunction

  function automatic void close_batch(int b);
    seal_batch(b);
    if (b < MAX_BATCHES) open_batch[batch_fam[b] % NUM_FAMILIES] = 0;
  endfunction

  function automatic void add_foreign(int b);
    int i;
    for (i = 0; i < foreign_cnt; i++) if (foreign[i] == b) return;
    if (foreign_cnt >= MAX_DEPS) begin
      ovf = 1'b1;
      return;
    end
    i = 0;
    while (i < foreign_cnt && foreign[i] < b) i++;
    for (int j = foreign_cnt; j > i; j--) foreign[j] = foreign[j-1];
    foreign[i] = b;
    foreign_cnt++;
  endfunction

  function automatic int open_new(int fam);
    int t;
    t = batch_cnt;
    batch_cnt++;
    batch_fam[t] = fam;
    batch_sig[t] = 0;
    open_batch[fam] = t + 1;
    push_event(EV_OPENED, t, 0, 0, fam, 0);
    return t;
  endfunction

  function automatic void plan_request(in_req_t r);
    int  fam;
    int  target;
    int  own;
    int  n0;
    bit  have_own;
    bit  placed;
    fam = r.pass_family % NUM_FAMILIES;
    target = 0;
    own = 0;
    have_own = 1'b0;
    placed = 1'b1;
    n0 = event_q.size();
    if (r.req_type == REQ_END) begin
      for (int i = 0; i < NUM_FAMILIES; i++)
        if (open_batch[i] != 0) seal_batch(open_batch[i] - 1);
      push_event(EV_DONE, 0, ovf, batch_cnt, 0, 0);
      clear_plan();
      event_q[event_q.size()-1].last = 1'b1;
      return;
    end
    if (r.dep_valid && pass_batch[r.dep_index] != 0) begin
      if (batch_fam[pass_batch[r.dep_index] - 1] != fam)
        add_foreign(pass_batch[r.dep_index] - 1);
    end
    if (!r.last_of_pass) return;
    if (foreign_cnt > 0) begin
      for (int i = 0; i < foreign_cnt; i++) close_batch(foreign[i]);
      if (open_batch[fam] != 0) begin
        own = open_batch[fam] - 1;
        have_own = 1'b1;
        close_batch(own);
      end
      if (batch_cnt >= MAX_BATCHES) begin
        placed = 1'b0;
      end else begin
        target = open_new(fam);
        if (have_own) push_event(EV_WAIT, target, own, batch_sig[own], fam, 0);
        for (int i = 0; i < foreign_cnt; i++)
          push_event(EV_WAIT, target, foreign[i], batch_sig[foreign[i]], fam, 0);
      end
    end else if (open_batch[fam] != 0) begin
      target = open_batch[fam] - 1;
    end else if (batch_cnt >= MAX_BATCHES) begin
      placed = 1'b0;
    end else begin
      target = open_new(fam);
    end
    if (placed) begin
      push_event(EV_ASSIGN, target, 0, 0, fam, r.pass_index);
      pass_batch[r.pass_index] = target + 1;
    end else begin
      ovf = 1'b1;
      push_event(EV_OVERFLOW, 0, 0, 0, fam, r.pass_index);
    end
    foreign_cnt = 0;
    if (event_q.size() > n0) event_q[event_q.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (event_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_res);
        err_cnt++;
      end else begin
        if (out_res !== event_q[0]) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, event_q[0], out_res);
          err_cnt++;
        end
        void'(event_q.pop_front());
      end
    end
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic send_req(in_req_t r);
    start = 1'b1;
    in_req = r;
    do @(posedge clk); while (busy);
    plan_request(r);
    req_cnt++;
    @(negedge clk);
    start = 1'b0;
    while ($urandom_range(99) < idle_pct) @(negedge clk);
  endtask

  task automatic send_item(logic rt, int pidx, int fam, int dep, logic dv, logic lp);
    in_req_t r;
    r.req_type = rt;
    r.pass_index = pidx[PASS_W-1:0];
    r.pass_family = fam[1:0];
    r.dep_index = dep[PASS_W-1:0];
    r.dep_valid = dv;
    r.last_of_pass = lp;
    send_req(r);
  endtask

  task automatic drain();
    while (event_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic end_graph();
    send_item(REQ_END, $urandom_range(255), $urandom_range(3), $urandom_range(255),
              $urandom_range(1), $urandom_range(1));
    placed_q.delete();
  endtask

  task automatic test_directed();
    send_item(REQ_DEP, 0, 0, 255, 1'b0, 1'b1);
    send_item(REQ_DEP, 1, 0, 0, 1'b1, 1'b1);
    send_item(REQ_DEP, 2, 1, 0, 1'b1, 1'b1);
    send_item(REQ_DEP, 200, 3, 77, 1'b1, 1'b0);
    send_item(REQ_DEP, 9, 2, 1, 1'b1, 1'b0);
    send_item(REQ_DEP, 3, 2, 2, 1'b1, 1'b0);
    send_item(REQ_DEP, 3, 2, 2, 1'b0, 1'b1);
    send_item(REQ_DEP, 4, 0, 3, 1'b1, 1'b1);
    send_item(REQ_DEP, 5, 1, 250, 1'b1, 1'b1);
    send_item(REQ_DEP, 255, 3, 4, 1'b1, 1'b1);
    send_item(REQ_DEP, 6, 1, 255, 1'b1, 1'b0);
    send_item(REQ_END, 255, 3, 255, 1'b1, 1'b1);
    send_item(REQ_DEP, 7, 0, 0, 1'b1, 1'b1);
    send_item(REQ_END, 0, 0, 0, 1'b0, 1'b0);
    drain();
  endtask

  // A chain of passes in alternating families, then one pass that depends on
  // more foreign batches than the list can hold.
  task automatic test_foreign_full();
    for (int p = 0; p < 17; p++)
      send_item(REQ_DEP, p, p % 2, p - 1, p > 0, 1'b1);
    for (int p = 0; p < 17; p++)
      send_item(REQ_DEP, 20, 2, p, 1'b1, p == 16);
    end_graph();
    drain();
  endtask

  task automatic test_batch_full();
    for (int p = 0; p < 258; p++)
      send_item(REQ_DEP, p % 256, p % 2, (p + 255) % 256, p > 0, 1'b1);
    end_graph();
    drain();
  endtask

  task automatic send_pass();
    int pidx;
    int fam;
    int ndeps;
    int dep;
    bit dv;
    pidx = next_pass;
    next_pass = (next_pass + 1 + ($urandom_range(9) == 0 ? $urandom_range(255) : 0)) % 256;
    fam = $urandom_range(3);
    ndeps = $urandom_range(5) + 1;
    for (int k = 0; k < ndeps; k++) begin
      dv = 1'b1;
      if (placed_q.size() != 0 && $urandom_range(9) < 8) begin
        dep = placed_q[$urandom_range(placed_q.size() - 1)];
      end else begin
        dep = $urandom_range(255);
        dv = $urandom_range(1);
      end
      if (k == ndeps - 1) send_item(REQ_DEP, pidx, fam, dep, dv, 1'b1);
      else send_item(REQ_DEP, $urandom_range(255), $urandom_range(3), dep, dv, 1'b0);
      if (k != ndeps - 1 && $urandom_range(49) == 0) begin
        end_graph();
        return;
      end
    end
    placed_q = {placed_q, pidx};
  endtask

  task automatic test_random(int n, int pct);
    int stop_at;
    idle_pct = pct;
    stop_at = req_cnt + n;
    while (req_cnt < stop_at) begin
      if ($urandom_range(39) == 0) end_graph();
      else send_pass();
    end
    end_graph();
    drain();
    idle_pct = 0;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    clear_plan();
    test_directed();
    test_foreign_full();
    test_batch_full();
    test_random(15, 0);
    test_random(15, 60);
    test_random(10, 9);
    test_random(10, 0);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
src/qbp_pkg.sv
src/qbp_dp.sv
src/qbp_ctrl.sv
src/queue_batch_planner.sv
tb/sv/tb_queue_batch_planner.sv
